// ===== design/set_assoc_writeback_cache_assert.svh =====
// Assertion macros for the set-associative write-back cache.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef SET_ASSOC_WRITEBACK_CACHE_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define SAWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SAWC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`else
`define SAWC_ASSERT(lbl, prop, msg)
`define SAWC_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

// ===== design/sawc_pkg.sv =====
// Shared types and constants for the set-associative write-back cache.
// No dependencies.
package sawc_pkg;

  localparam int unsigned MaxLines      = 256;
  localparam int unsigned MaxBlockWords = 16;
  localparam int unsigned MemWords      = 65536;
  localparam int unsigned WordBits      = 32;
  localparam int unsigned LineW         = $clog2(MaxLines);
  localparam int unsigned OffW          = $clog2(MaxBlockWords);
  localparam int unsigned AddrW         = $clog2(MemWords);
  localparam int unsigned LwAddrW       = LineW + OffW;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_PRELOAD = 2'd2,
    CMD_FLUSH   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_TO_PROC   = 3'd0,
    ACT_FROM_PROC = 3'd1,
    ACT_FILL      = 3'd2,
    ACT_WB        = 3'd3,
    ACT_DROP      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_BLOCK = 2'd0,
    CFG_SETS  = 2'd1,
    CFG_WAYS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FLUSH_RD, S_SCAN_RD, S_SCAN_CMP, S_DECIDE,
    S_WB_RD, S_WB_WR, S_WB_EMIT, S_FILL_RD, S_FILL_WR, S_FILL_EMIT,
    S_TOUCH_RD, S_TOUCH_WR, S_ACC, S_ACC_EMIT
  } state_e;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  age;
  } meta_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [AddrW-1:0]    start_addr;
    logic [4:0]          length;
    logic [WordBits-1:0] read_data;
    logic                was_hit;
    logic [31:0]         hit_total;
    logic [31:0]         miss_total;
    logic                last;
  } rec_t;

endpackage

// ===== design/sawc_if.sv =====
// Valid/ready channel interfaces for requests and transfer records.
// No dependencies.
interface sawc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [31:0] write_data;
  logic [7:0]  flush_set;
  logic [7:0]  flush_way;
  modport source (output valid, cmd, addr, write_data, flush_set, flush_way, input ready);
  modport sink (input valid, cmd, addr, write_data, flush_set, flush_way, output ready);
endinterface

interface sawc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] start_addr;
  logic [4:0]  length;
  logic [31:0] read_data;
  logic        was_hit;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic        last;
  modport source (output valid, action, start_addr, length, read_data, was_hit,
                  hit_total, miss_total, last, input ready);
  modport sink (input valid, action, start_addr, length, read_data, was_hit,
                hit_total, miss_total, last, output ready);
endinterface

// ===== design/set_assoc_writeback_cache.sv =====
// Per word: a preload, or a flush with nothing to write back, completes on acceptance; a dirty
// flush writes the block back; a hit scans the ways up to the hit, then updates every way's age;
// a miss scans all ways, drops a clean victim or writes back a dirty one, fills, then ages.
// One word at a time, held up by a stalled output record; the sequencer walking ways and words
// over one-port memories sets the pace. Reset: all lines invalid, then a pass zeroes the word
// memory, no word taken meanwhile (config writes are). Needs sawc_pkg, sawc_if.
`include "set_assoc_writeback_cache_assert.svh"
module set_assoc_writeback_cache (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [3:0]       cfg_wdata_i,
  sawc_in_if.sink          in_if,
  sawc_out_if.source       out_if
);

  localparam int unsigned LineW   = sawc_pkg::LineW;
  localparam int unsigned AddrW   = sawc_pkg::AddrW;
  localparam int unsigned LwAddrW = sawc_pkg::LwAddrW;
  localparam int unsigned WordW   = sawc_pkg::WordBits;

  function automatic logic [LineW-1:0] line_of(input logic [7:0] s, input logic [7:0] w,
                                               input logic [3:0] l);
    return LineW'(s << l) + LineW'(w);
  endfunction

  // configuration
  logic [2:0] cfg_blk_q;
  logic [3:0] cfg_sets_q, cfg_ways_q;
  logic [2:0] lb;
  logic [3:0] ls, lw, lbls;
  logic [4:0] words;
  logic [8:0] ways, nsets;
  logic [7:0] ways_m1, set_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_blk_q  <= '0;
      cfg_sets_q <= '0;
      cfg_ways_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sawc_pkg::CFG_BLOCK: cfg_blk_q  <= cfg_wdata_i[2:0];
        sawc_pkg::CFG_SETS:  cfg_sets_q <= cfg_wdata_i;
        sawc_pkg::CFG_WAYS:  cfg_ways_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    lb       = (cfg_blk_q > 3'd4) ? 3'd4 : cfg_blk_q;
    ls       = (cfg_sets_q > 4'd8) ? 4'd8 : cfg_sets_q;
    lw       = (cfg_ways_q > (4'd8 - ls)) ? (4'd8 - ls) : cfg_ways_q;
    lbls     = {1'b0, lb} + ls;
    words    = 5'd1 << lb;
    ways     = 9'd1 << lw;
    nsets    = 9'd1 << ls;
    ways_m1  = 8'(ways - 9'd1);
    set_mask = 8'(nsets - 9'd1);
  end

  // memories
  logic [WordW-1:0] mem_q [sawc_pkg::MemWords];
  logic [WordW-1:0] mem_rdata_q, mem_wdata;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  logic             mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem_q[mem_raddr];
  end

  logic [WordW-1:0]   lw_q [sawc_pkg::MaxLines * sawc_pkg::MaxBlockWords];
  logic [WordW-1:0]   lw_rdata_q, lw_wdata;
  logic [LwAddrW-1:0] lw_raddr, lw_waddr;
  logic               lw_we;

  always_ff @(posedge clk_i) begin
    if (lw_we) lw_q[lw_waddr] <= lw_wdata;
    lw_rdata_q <= lw_q[lw_raddr];
  end

  sawc_pkg::meta_t  meta_q [sawc_pkg::MaxLines];
  sawc_pkg::meta_t  meta_rdata_q, meta_wdata;
  logic [LineW-1:0] meta_raddr, meta_waddr;
  logic             meta_we;

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_q[meta_waddr] <= meta_wdata;
    meta_rdata_q <= meta_q[meta_raddr];
  end

  // per-line flags; an entry not yet aged reads as ways minus one
  logic [sawc_pkg::MaxLines-1:0] valid_q, dirty_q, aged_q;
  logic             vd_we, vd_valid, vd_dirty, aged_we;
  logic [LineW-1:0] vd_line;

  // sequencer registers
  sawc_pkg::state_e state_q, state_d;
  logic [8:0]        k_q, k_d;
  logic [15:0]       clr_q, clr_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [15:0]       addr_q, addr_d, tag_q, tag_d, vtag_q, vtag_d, best_tag_q, best_tag_d;
  logic [WordW-1:0]  wd_q, wd_d;
  logic [7:0]        set_q, set_d, way_q, way_d, inv_way_q, inv_way_d;
  logic [7:0]        best_way_q, best_way_d, inv_age_q, inv_age_d, best_age_q, best_age_d;
  logic [7:0]        old_age_q, old_age_d;
  logic [3:0]        off_q, off_d;
  logic [LineW-1:0]  line_q, line_d;
  logic              hit_q, hit_d, inv_found_q, inv_found_d;
  logic [2:0]        vact_q, vact_d;
  logic [31:0]       hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d;

  logic              out_valid_q, out_load, out_free;
  sawc_pkg::rec_t    out_rec_q, rec_d;

  logic [LineW-1:0]  cur_line, fl_line, dec_line;
  logic [7:0]        cur_age;
  logic [15:0]       vbase, fbase;
  logic              last_way, last_word;

  always_comb begin
    cur_line  = line_of(set_q, k_q[7:0], lw);
    fl_line   = line_of(in_if.flush_set, in_if.flush_way, lw);
    dec_line  = line_of(set_q, best_way_q, lw);
    cur_age   = aged_q[cur_line] ? meta_rdata_q.age : ways_m1;
    vbase     = 16'(vtag_q << lbls) | 16'({8'd0, set_q} << lb);
    fbase     = addr_q & ~16'(words - 5'd1);
    last_way  = (k_q + 9'd1) == ways;
    last_word = (k_q + 9'd1) == {4'd0, words};
    out_free  = !out_valid_q || out_if.ready;
  end

  always_comb begin
    state_d = state_q;  k_d = k_q;  clr_d = clr_q;
    cmd_d = cmd_q;  addr_d = addr_q;  tag_d = tag_q;  vtag_d = vtag_q;
    best_tag_d = best_tag_q;  wd_d = wd_q;  set_d = set_q;  way_d = way_q;
    inv_way_d = inv_way_q;  best_way_d = best_way_q;  inv_age_d = inv_age_q;
    best_age_d = best_age_q;  old_age_d = old_age_q;  off_d = off_q;
    line_d = line_q;  hit_d = hit_q;  inv_found_d = inv_found_q;  vact_d = vact_q;
    hit_cnt_d = hit_cnt_q;  miss_cnt_d = miss_cnt_q;
    in_if.ready = 1'b0;
    mem_we = 1'b0;  mem_waddr = AddrW'(vbase + 16'(k_q));  mem_wdata = lw_rdata_q;
    mem_raddr = AddrW'(fbase + 16'(k_q));
    lw_we = 1'b0;  lw_waddr = {line_q, k_q[3:0]};  lw_wdata = mem_rdata_q;
    lw_raddr = {line_q, off_q};
    meta_we = 1'b0;  meta_waddr = cur_line;  meta_raddr = cur_line;
    meta_wdata = '{tag: meta_rdata_q.tag, age: cur_age};
    vd_we = 1'b0;  vd_line = line_q;  vd_valid = 1'b0;  vd_dirty = 1'b0;  aged_we = 1'b0;
    out_load = 1'b0;
    rec_d = '{action: vact_q, start_addr: vbase, length: words, read_data: '0,
              was_hit: 1'b0, hit_total: hit_cnt_q, miss_total: miss_cnt_q, last: 1'b0};

    unique case (state_q)
      sawc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(clr_q);
        mem_wdata = '0;
        clr_d     = clr_q + 16'd1;
        if (&clr_q) state_d = sawc_pkg::S_IDLE;
      end
      sawc_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cmd_d = in_if.cmd;  addr_d = in_if.addr;  wd_d = in_if.write_data;
          k_d = '0;  hit_d = 1'b0;  inv_found_d = 1'b0;
          unique case (in_if.cmd)
            sawc_pkg::CMD_PRELOAD: begin
              mem_we    = 1'b1;
              mem_waddr = AddrW'(in_if.addr);
              mem_wdata = in_if.write_data;
            end
            sawc_pkg::CMD_FLUSH: begin
              set_d = in_if.flush_set;
              if ({1'b0, in_if.flush_set} < nsets && {1'b0, in_if.flush_way} < ways) begin
                line_d = fl_line;
                if (valid_q[fl_line] && dirty_q[fl_line]) begin
                  meta_raddr = fl_line;
                  state_d    = sawc_pkg::S_FLUSH_RD;
                end else begin
                  vd_we   = 1'b1;
                  vd_line = fl_line;
                end
              end
            end
            default: begin
              set_d   = 8'(in_if.addr >> lb) & set_mask;
              tag_d   = in_if.addr >> lbls;
              off_d   = 4'(in_if.addr & 16'(words - 5'd1));
              state_d = sawc_pkg::S_SCAN_RD;
            end
          endcase
        end
      end
      sawc_pkg::S_FLUSH_RD: begin
        vtag_d  = meta_rdata_q.tag;
        vact_d  = sawc_pkg::ACT_WB;
        state_d = sawc_pkg::S_WB_RD;
      end
      sawc_pkg::S_SCAN_RD: state_d = sawc_pkg::S_SCAN_CMP;
      sawc_pkg::S_SCAN_CMP: begin
        if (valid_q[cur_line] && meta_rdata_q.tag == tag_q) begin
          hit_d     = 1'b1;
          way_d     = k_q[7:0];
          line_d    = cur_line;
          old_age_d = cur_age;
          hit_cnt_d = hit_cnt_q + 32'd1;
          k_d       = '0;
          state_d   = sawc_pkg::S_TOUCH_RD;
        end else begin
          if (!valid_q[cur_line] && !inv_found_q) begin
            inv_found_d = 1'b1;
            inv_way_d   = k_q[7:0];
            inv_age_d   = cur_age;
          end
          // oldest way, lowest index on ties
          if (k_q == 9'd0 || cur_age > best_age_q) begin
            best_way_d = k_q[7:0];
            best_age_d = cur_age;
            best_tag_d = meta_rdata_q.tag;
          end
          if (last_way) begin
            state_d = sawc_pkg::S_DECIDE;
          end else begin
            k_d     = k_q + 9'd1;
            state_d = sawc_pkg::S_SCAN_RD;
          end
        end
      end
      sawc_pkg::S_DECIDE: begin
        miss_cnt_d = miss_cnt_q + 32'd1;
        k_d        = '0;
        if (inv_found_q) begin
          way_d     = inv_way_q;
          old_age_d = inv_age_q;
          line_d    = line_of(set_q, inv_way_q, lw);
          state_d   = sawc_pkg::S_FILL_RD;
        end else begin
          way_d     = best_way_q;
          old_age_d = best_age_q;
          line_d    = dec_line;
          vtag_d    = best_tag_q;
          if (dirty_q[dec_line]) begin
            vact_d  = sawc_pkg::ACT_WB;
            state_d = sawc_pkg::S_WB_RD;
          end else begin
            vact_d  = sawc_pkg::ACT_DROP;
            state_d = sawc_pkg::S_WB_EMIT;
          end
        end
      end
      sawc_pkg::S_WB_RD: begin
        lw_raddr = {line_q, k_q[3:0]};
        state_d  = sawc_pkg::S_WB_WR;
      end
      sawc_pkg::S_WB_WR: begin
        mem_we = 1'b1;
        if (last_word) begin
          state_d = sawc_pkg::S_WB_EMIT;
        end else begin
          k_d     = k_q + 9'd1;
          state_d = sawc_pkg::S_WB_RD;
        end
      end
      sawc_pkg::S_WB_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          rec_d.last = (cmd_q == sawc_pkg::CMD_FLUSH);
          k_d        = '0;
          if (cmd_q == sawc_pkg::CMD_FLUSH) begin
            vd_we   = 1'b1;
            state_d = sawc_pkg::S_IDLE;
          end else begin
            state_d = sawc_pkg::S_FILL_RD;
          end
        end
      end
      sawc_pkg::S_FILL_RD: state_d = sawc_pkg::S_FILL_WR;
      sawc_pkg::S_FILL_WR: begin
        lw_we = 1'b1;
        if (last_word) begin
          state_d = sawc_pkg::S_FILL_EMIT;
        end else begin
          k_d     = k_q + 9'd1;
          state_d = sawc_pkg::S_FILL_RD;
        end
      end
      sawc_pkg::S_FILL_EMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          rec_d.action     = sawc_pkg::ACT_FILL;
          rec_d.start_addr = fbase;
          vd_we            = 1'b1;
          vd_valid         = 1'b1;
          k_d              = '0;
          state_d          = sawc_pkg::S_TOUCH_RD;
        end
      end
      sawc_pkg::S_TOUCH_RD: state_d = sawc_pkg::S_TOUCH_WR;
      sawc_pkg::S_TOUCH_WR: begin
        meta_we = 1'b1;
        aged_we = 1'b1;
        if (k_q[7:0] == way_q) begin
          meta_wdata = '{tag: tag_q, age: 8'd0};
        end else if (cur_age < old_age_q) begin
          meta_wdata.age = cur_age + 8'd1;
        end
        if (last_way) begin
          state_d = sawc_pkg::S_ACC;
        end else begin
          k_d     = k_q + 9'd1;
          state_d = sawc_pkg::S_TOUCH_RD;
        end
      end
      sawc_pkg::S_ACC: begin
        if (cmd_q == sawc_pkg::CMD_WRITE) begin
          lw_we    = 1'b1;
          lw_waddr = {line_q, off_q};
          lw_wdata = wd_q;
          vd_we    = 1'b1;
          vd_valid = 1'b1;
          vd_dirty = 1'b1;
        end
        state_d = sawc_pkg::S_ACC_EMIT;
      end
      sawc_pkg::S_ACC_EMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          rec_d.action     = (cmd_q == sawc_pkg::CMD_WRITE) ? sawc_pkg::ACT_FROM_PROC
                                                            : sawc_pkg::ACT_TO_PROC;
          rec_d.start_addr = addr_q;
          rec_d.length     = 5'd1;
          rec_d.read_data  = (cmd_q == sawc_pkg::CMD_WRITE) ? '0 : lw_rdata_q;
          rec_d.was_hit    = hit_q;
          rec_d.last       = 1'b1;
          state_d          = sawc_pkg::S_IDLE;
        end
      end
      default: state_d = sawc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sawc_pkg::S_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      hit_q       <= 1'b0;
      inv_found_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      cmd_q       <= sawc_pkg::CMD_READ;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
      inv_found_q <= inv_found_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;  tag_q <= tag_d;  vtag_q <= vtag_d;  best_tag_q <= best_tag_d;
    wd_q <= wd_d;  set_q <= set_d;  way_q <= way_d;  inv_way_q <= inv_way_d;
    best_way_q <= best_way_d;  inv_age_q <= inv_age_d;  best_age_q <= best_age_d;
    old_age_q <= old_age_d;  off_q <= off_d;  line_q <= line_d;  vact_q <= vact_d;
  end

  // only writes to a defined register drop the lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      aged_q  <= '0;
    end else if (cfg_we_i && cfg_idx_i <= sawc_pkg::CFG_WAYS) begin
      valid_q <= '0;
      dirty_q <= '0;
      aged_q  <= '0;
    end else begin
      if (vd_we) begin
        valid_q[vd_line] <= vd_valid;
        dirty_q[vd_line] <= vd_dirty;
      end
      if (aged_we) aged_q[cur_line] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_rec_q <= rec_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.action     = out_rec_q.action;
  assign out_if.start_addr = out_rec_q.start_addr;
  assign out_if.length     = out_rec_q.length;
  assign out_if.read_data  = out_rec_q.read_data;
  assign out_if.was_hit    = out_rec_q.was_hit;
  assign out_if.hit_total  = out_rec_q.hit_total;
  assign out_if.miss_total = out_rec_q.miss_total;
  assign out_if.last       = out_rec_q.last;

  `SAWC_ASSERT(a_one_count, !(!$stable(hit_cnt_q) && !$stable(miss_cnt_q)), "hit and miss counted together")
  `SAWC_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || out_if.ready, "record overwritten")
  `SAWC_ASSERT_IMP(a_acc_valid, state_q == sawc_pkg::S_ACC_EMIT, valid_q[line_q], "access to invalid line")

endmodule

// ===== tb/sawc_checker.sv =====
// Scoreboard for the set-associative write-back cache: predicts the transfer
// records of every accepted word and compares them with the records taken out.
// Depends on sawc_pkg and sawc_if.
module sawc_checker
  import sawc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  sawc_in_if          in_mon,
  sawc_out_if         out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  bit [2:0]  reg_block;
  bit [3:0]  reg_sets;
  bit [3:0]  reg_ways;

  bit        valid_q [MaxLines];
  bit        dirty_q [MaxLines];
  bit [15:0] tag_q   [MaxLines];
  bit [7:0]  age_q   [MaxLines];
  bit [31:0] words_q [MaxLines*MaxBlockWords];
  bit [31:0] mem_q   [MemWords];
  bit [31:0] hits;
  bit [31:0] misses;

  rec_t expected_recs[$];

  function automatic void geometry(output int unsigned lb, output int unsigned ls,
                                   output int unsigned lw);
    lb = (reg_block > 4) ? 4 : reg_block;
    ls = (reg_sets > 8) ? 8 : reg_sets;
    lw = (reg_ways > 8 - ls) ? 8 - ls : reg_ways;
  endfunction

  function automatic void invalidate_all();
    int unsigned lb, ls, lw;
    geometry(lb, ls, lw);
    for (int i = 0; i < MaxLines; i++) begin
      valid_q[i] = 0;
      dirty_q[i] = 0;
      tag_q[i]   = '0;
      age_q[i]   = 8'((1 << lw) - 1);
    end
  endfunction

  function automatic int unsigned line_idx(int unsigned set_i, int unsigned way,
                                           int unsigned lw);
    return ((set_i << lw) + way) % MaxLines;
  endfunction

  function automatic void emit(action_e act, int unsigned start, int unsigned len,
                               bit [31:0] data, bit hit);
    rec_t r;
    r.action     = act;
    r.start_addr = 16'(start);
    r.length     = 5'(len);
    r.read_data  = data;
    r.was_hit    = hit;
    r.hit_total  = hits;
    r.miss_total = misses;
    r.last       = 1'b0;
    expected_recs.push_back(r);
  endfunction

  // true LRU: ways younger than the touched one age by one
  function automatic void touch(int unsigned set_i, int unsigned way, int unsigned lw);
    int unsigned t;
    bit [7:0] old;
    t   = line_idx(set_i, way, lw);
    old = age_q[t];
    for (int unsigned j = 0; j < (1 << lw); j++)
      if (age_q[line_idx(set_i, j, lw)] < old) age_q[line_idx(set_i, j, lw)]++;
    age_q[t] = 0;
  endfunction

  function automatic void spill(int unsigned ln, int unsigned base, int unsigned words);
    for (int unsigned k = 0; k < words; k++)
      mem_q[16'(base + k)] = words_q[ln*MaxBlockWords + k];
  endfunction

  function automatic void predict(cmd_e c, bit [15:0] a, bit [31:0] d,
                                  bit [7:0] fs, bit [7:0] fw);
    int unsigned lb, ls, lw, words, ways, set_i, off, way, ln, base, first;
    bit [7:0] best;
    bit [15:0] tg;
    bit hit, found;
    geometry(lb, ls, lw);
    words = 1 << lb;
    ways  = 1 << lw;
    first = expected_recs.size();
    hit   = 0;
    found = 0;
    way   = 0;
    best  = 0;
    if (c == CMD_PRELOAD) begin
      mem_q[a] = d;
    end else if (c == CMD_FLUSH) begin
      if (fs < (1 << ls) && fw < ways) begin
        ln = line_idx(fs, fw, lw);
        if (valid_q[ln] && dirty_q[ln]) begin
          base = (tag_q[ln] << (lb + ls)) | (fs << lb);
          spill(ln, base, words);
          emit(ACT_WB, base, words, '0, 0);
        end
        valid_q[ln] = 0;
        dirty_q[ln] = 0;
      end
    end else begin
      off   = a & (words - 1);
      set_i = (a >> lb) & ((1 << ls) - 1);
      tg    = 16'(a >> (lb + ls));
      for (int unsigned k = 0; k < ways; k++) begin
        ln = line_idx(set_i, k, lw);
        if (!hit && valid_q[ln] && tag_q[ln] == tg) begin
          hit = 1;
          way = k;
        end
      end
      if (hit) begin
        hits++;
      end else begin
        misses++;
        for (int unsigned k = 0; k < ways; k++)
          if (!found && !valid_q[line_idx(set_i, k, lw)]) begin
            way   = k;
            found = 1;
          end
        if (!found)
          for (int unsigned k = 0; k < ways; k++)
            if (k == 0 || age_q[line_idx(set_i, k, lw)] > best) begin
              best = age_q[line_idx(set_i, k, lw)];
              way  = k;
            end
        ln   = line_idx(set_i, way, lw);
        base = (tag_q[ln] << (lb + ls)) | (set_i << lb);
        if (valid_q[ln] && dirty_q[ln]) begin
          spill(ln, base, words);
          emit(ACT_WB, base, words, '0, 0);
        end else if (valid_q[ln]) begin
          emit(ACT_DROP, base, words, '0, 0);
        end
        base = a & ~(words - 1);
        for (int unsigned k = 0; k < words; k++)
          words_q[ln*MaxBlockWords + k] = mem_q[16'(base + k)];
        emit(ACT_FILL, base, words, '0, 0);
        tag_q[ln]   = tg;
        valid_q[ln] = 1;
        dirty_q[ln] = 0;
      end
      ln = line_idx(set_i, way, lw);
      touch(set_i, way, lw);
      if (c == CMD_WRITE) begin
        words_q[ln*MaxBlockWords + off] = d;
        dirty_q[ln] = 1;
        emit(ACT_FROM_PROC, a, 1, '0, hit);
      end else begin
        emit(ACT_TO_PROC, a, 1, words_q[ln*MaxBlockWords + off], hit);
      end
    end
    if (expected_recs.size() > first) expected_recs[expected_recs.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      logic [31:0] act_v);
    if (^act_v === 1'bx || act_v != exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    invalidate_all();
  end

  always @(posedge clk_i) begin
    rec_t exp_r;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK: reg_block = cfg_wdata_i[2:0];
          CFG_SETS:  reg_sets  = cfg_wdata_i;
          CFG_WAYS:  reg_ways  = cfg_wdata_i;
          default: ;
        endcase
        if (cfg_idx_i <= CFG_WAYS) invalidate_all();
      end
      if (in_mon.valid && in_mon.ready)
        predict(cmd_e'(in_mon.cmd), in_mon.addr, in_mon.write_data,
                in_mon.flush_set, in_mon.flush_way);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_recs.size() == 0) begin
          $error("record with no word pending: action %0d start %0h",
                 out_mon.action, out_mon.start_addr);
          fail_cnt_o++;
        end else begin
          exp_r = expected_recs.pop_front();
          check_field("action", exp_r.action, out_mon.action);
          check_field("start_addr", exp_r.start_addr, out_mon.start_addr);
          check_field("length", exp_r.length, out_mon.length);
          check_field("read_data", exp_r.read_data, out_mon.read_data);
          check_field("was_hit", exp_r.was_hit, out_mon.was_hit);
          check_field("hit_total", exp_r.hit_total, out_mon.hit_total);
          check_field("miss_total", exp_r.miss_total, out_mon.miss_total);
          check_field("last", exp_r.last, out_mon.last);
        end
      end
      pending_o = expected_recs.size();
    end
  end

endmodule

// ===== tb/tb_set_assoc_writeback_cache.sv =====
// Stimulus and verdict for the set-associative write-back cache.
// Drives config writes and request words; checking lives in sawc_checker.
// Depends on sawc_pkg, sawc_if, sawc_checker and the cache RTL.
module tb_set_assoc_writeback_cache;
  import sawc_pkg::*;

  localparam int unsigned StallLimit = 200000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [3:0] cfg_wdata_i;

  int unsigned fail_cnt;
  int unsigned pending;
  bit          calm;
  bit          hold_req;
  bit [7:0]    tag_pool[4];

  sawc_in_if  in_if ();
  sawc_out_if out_if ();

  set_assoc_writeback_cache u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  sawc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // record sink: random stalls, or a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (500) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // watchdog on cycles without any handshake; covers the memory clearing pass
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_set_assoc_writeback_cache failed");
        $finish;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_word(cmd_e c, logic [15:0] a, logic [31:0] d,
                           logic [7:0] fs, logic [7:0] fw);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= c;
    in_if.addr       <= a;
    in_if.write_data <= d;
    in_if.flush_set  <= fs;
    in_if.flush_way  <= fw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [3:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait out all records, then the tail of any word that makes none
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (1500) @(negedge clk_i);
  endtask

  task automatic random_word();
    int unsigned r;
    logic [15:0] a;
    logic [7:0]  fs;
    logic [7:0]  fw;
    cmd_e c;
    r = $urandom_range(0, 99);
    c = (r < 40) ? CMD_READ : (r < 75) ? CMD_WRITE : (r < 87) ? CMD_PRELOAD : CMD_FLUSH;
    if ($urandom_range(0, 9) == 0) a = 16'($urandom);
    else a = {tag_pool[$urandom_range(0, 3)], 8'($urandom_range(0, 31))};
    fs = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    fw = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    send_word(c, a, $urandom, fs, fw);
  endtask

  initial begin
    int unsigned geo[7][4];
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_BLOCK;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_READ;
    in_if.addr       = '0;
    in_if.write_data = '0;
    in_if.flush_set  = '0;
    in_if.flush_way  = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    // block, sets, ways, word count
    geo = '{'{1, 1, 1, 70}, '{0, 0, 0, 40}, '{2, 3, 1, 80}, '{4, 0, 15, 15},
            '{15, 15, 15, 60}, '{4, 2, 3, 80}, '{3, 4, 2, 100}};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) drain();
      cfg_write(CFG_BLOCK, 4'(geo[p][0]));
      cfg_write(CFG_SETS, 4'(geo[p][1]));
      cfg_write(CFG_WAYS, 4'(geo[p][2]));
      tag_pool = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
      if (p == 0) begin
        // two sets of two ways, two-word blocks: tags 0, 1, 2 share set 0
        send_word(CMD_PRELOAD, 16'h0000, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_word(CMD_PRELOAD, 16'hFFFF, 32'hA5A5_5A5A, 8'hFF, 8'hFF);
        send_word(CMD_READ,    16'h0000, 32'h0, 8'h00, 8'h00);
        send_word(CMD_READ,    16'h0001, 32'h0, 8'h00, 8'h00);
        send_word(CMD_WRITE,   16'h0000, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_word(CMD_READ,    16'h0004, 32'h0, 8'h00, 8'h00);
        send_word(CMD_READ,    16'h0008, 32'h0, 8'h00, 8'h00); // dirty victim
        send_word(CMD_READ,    16'h000C, 32'h0, 8'h00, 8'h00); // clean victim
        send_word(CMD_WRITE,   16'hFFFF, 32'h0000_0000, 8'h00, 8'h00);
        send_word(CMD_READ,    16'hFFFE, 32'h0, 8'h00, 8'h00);
        send_word(CMD_FLUSH,   16'h0000, 32'h0, 8'h01, 8'h00);
        send_word(CMD_FLUSH,   16'h0000, 32'h0, 8'h01, 8'h01);
        send_word(CMD_FLUSH,   16'h0000, 32'h0, 8'hFF, 8'h00); // set out of range
        send_word(CMD_FLUSH,   16'h0000, 32'h0, 8'h00, 8'hFF); // way out of range
        send_word(CMD_READ,    16'hFFFF, 32'h0, 8'h00, 8'h00);
        send_word(CMD_WRITE,   16'h0000, 32'h0000_0000, 8'h00, 8'h00);
        send_word(CMD_FLUSH,   16'h0000, 32'h0, 8'h00, 8'h00);
        send_word(CMD_FLUSH,   16'h0000, 32'h0, 8'h00, 8'h01);
      end
      if (p == 6) hold_req = 1'b1;
      for (int i = 0; i < geo[p][3]; i++) begin
        calm = (p == 2 && i >= 20 && i < 60);
        if (p == 2 && i == 40) drain();
        random_word();
      end
      calm = 1'b0;
    end

    drain();
    if (fail_cnt == 0)
      $display("tb_set_assoc_writeback_cache passed");
    else
      $display("tb_set_assoc_writeback_cache failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sawc_pkg.sv
design/sawc_if.sv
design/set_assoc_writeback_cache.sv
tb/sawc_checker.sv
tb/tb_set_assoc_writeback_cache.sv
